// ===== rtl/cia_pkg.sv =====
package cia_pkg;

   // operation codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK  = 3'd0;
   localparam logic [2:0] ST_ADD = 3'd1;
   localparam logic [2:0] ST_SUB = 3'd2;
   localparam logic [2:0] ST_MUL = 3'd3;
   localparam logic [2:0] ST_DIV = 3'd4;

   // one quotient bit per divider stage
   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [2:0]         status;
   } rsp_type;

   // classified request as held in the queue
   typedef struct packed {
      req_type req;
      logic    div_err;
   } cmd_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== rtl/cia_front.sv =====
module cia_front (
   input  logic             start,
   input  cia_pkg::req_type req_payload,
   input  cia_pkg::qstat_type qstat,
   output logic             push,
   output cia_pkg::cmd_type push_data,
   output logic             busy
);
   import cia_pkg::*;

   // accept while the queue has room
   assign busy = qstat.full;
   assign push = start & ~qstat.full;

   // flag a zero divisor or minimum divided by minus one
   always_comb begin
      push_data.req     = req_payload;
      push_data.div_err = (req_payload.operation == OP_DIV) &&
                          ((req_payload.operand_b == 32'sd0) ||
                           ((req_payload.operand_a == 32'sh8000_0000) &&
                            (req_payload.operand_b == -32'sd1)));
   end

endmodule

// ===== rtl/cia_queue.sv =====
module cia_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cia_pkg::cmd_type  push_data,
   input  logic              pop,
   output cia_pkg::cmd_type  pop_data,
   output cia_pkg::qstat_type qstat
);
   import cia_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        slot_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push & ~qstat.full;
   assign do_pop      = pop & ~qstat.empty;
   assign pop_data    = slot_ff[rd_ptr_ff];

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the request
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/cia_back.sv =====
module cia_back (
   input  logic              clock,
   input  logic              reset,
   input  cia_pkg::qstat_type qstat,
   input  cia_pkg::cmd_type  pop_data,
   output logic              pop,
   output logic              rsp_strobe,
   output cia_pkg::rsp_type  rsp_payload
);
   import cia_pkg::*;

   // operand stage
   logic               m_vld_ff;
   logic [1:0]         m_op_ff;
   logic               m_derr_ff;
   logic               m_neg_ff;
   logic [32:0]        m_sum_ff;
   logic [63:0]        m_prod_ff;
   logic [31:0]        m_dvd_ff;
   logic [31:0]        m_dsr_ff;

   // divider stages, index = quotient bits done
   logic               d_vld_ff [DIV_STEPS+1];
   logic               d_div_ff [DIV_STEPS+1];
   logic               d_neg_ff [DIV_STEPS+1];
   logic [31:0]        d_res_ff [DIV_STEPS+1];
   logic [2:0]         d_st_ff  [DIV_STEPS+1];
   logic [31:0]        d_rem_ff [DIV_STEPS+1];
   logic [31:0]        d_quo_ff [DIV_STEPS+1];
   logic [31:0]        d_dsr_ff [DIV_STEPS+1];
   logic [31:0]        d_rem_in [DIV_STEPS];
   logic [31:0]        d_quo_in [DIV_STEPS];

   logic [32:0]        sum_in;
   logic [31:0]        a_mag, b_mag;
   logic [31:0]        res0_in;
   logic [2:0]         st0_in;
   logic [31:0]        out_res_in;
   logic               rsp_strobe_ff;
   rsp_type            rsp_payload_ff;

   // drain the queue every cycle; the pipeline never stalls
   assign pop = ~qstat.empty;

   assign sum_in = (pop_data.req.operation == OP_SUB) ?
                   {pop_data.req.operand_a[31], pop_data.req.operand_a} -
                   {pop_data.req.operand_b[31], pop_data.req.operand_b} :
                   {pop_data.req.operand_a[31], pop_data.req.operand_a} +
                   {pop_data.req.operand_b[31], pop_data.req.operand_b};
   assign a_mag = pop_data.req.operand_a[31] ? 32'(-pop_data.req.operand_a)
                                             : pop_data.req.operand_a;
   assign b_mag = pop_data.req.operand_b[31] ? 32'(-pop_data.req.operand_b)
                                             : pop_data.req.operand_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= pop;
      end
   end

   // form sum, product and magnitudes
   always_ff @(posedge clock) begin
      m_op_ff   <= pop_data.req.operation;
      m_derr_ff <= pop_data.div_err;
      m_neg_ff  <= pop_data.req.operand_a[31] ^ pop_data.req.operand_b[31];
      m_sum_ff  <= sum_in;
      m_prod_ff <= 64'($signed(pop_data.req.operand_a) * $signed(pop_data.req.operand_b));
      m_dvd_ff  <= a_mag;
      m_dsr_ff  <= b_mag;
   end

   // range check of add, subtract and multiply
   always_comb begin
      res0_in = '0;
      st0_in  = ST_OK;
      case (m_op_ff)
         OP_ADD: begin
            if (m_sum_ff[32] != m_sum_ff[31]) st0_in = ST_ADD;
            else res0_in = m_sum_ff[31:0];
         end
         OP_SUB: begin
            if (m_sum_ff[32] != m_sum_ff[31]) st0_in = ST_SUB;
            else res0_in = m_sum_ff[31:0];
         end
         OP_MUL: begin
            if (m_prod_ff[63:31] != {33{m_prod_ff[31]}}) st0_in = ST_MUL;
            else res0_in = m_prod_ff[31:0];
         end
         default: begin
            if (m_derr_ff) st0_in = ST_DIV;
         end
      endcase
   end

   // one restoring step per stage
   always_comb begin
      for (int s = 0; s < DIV_STEPS; s++) begin
         logic [32:0] trial;
         trial = {d_rem_ff[s], d_quo_ff[s][31]} - {1'b0, d_dsr_ff[s]};
         if (!trial[32]) begin
            d_rem_in[s] = trial[31:0];
            d_quo_in[s] = {d_quo_ff[s][30:0], 1'b1};
         end else begin
            d_rem_in[s] = {d_rem_ff[s][30:0], d_quo_ff[s][31]};
            d_quo_in[s] = {d_quo_ff[s][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STEPS; s++) d_vld_ff[s] <= 1'b0;
      end else begin
         d_vld_ff[0] <= m_vld_ff;
         for (int s = 0; s < DIV_STEPS; s++) d_vld_ff[s+1] <= d_vld_ff[s];
      end
   end

   // advance the divider line
   always_ff @(posedge clock) begin
      d_div_ff[0] <= (m_op_ff == OP_DIV) && !m_derr_ff;
      d_neg_ff[0] <= m_neg_ff;
      d_res_ff[0] <= res0_in;
      d_st_ff[0]  <= st0_in;
      d_rem_ff[0] <= '0;
      d_quo_ff[0] <= m_dvd_ff;
      d_dsr_ff[0] <= m_dsr_ff;
      for (int s = 0; s < DIV_STEPS; s++) begin
         d_div_ff[s+1] <= d_div_ff[s];
         d_neg_ff[s+1] <= d_neg_ff[s];
         d_res_ff[s+1] <= d_res_ff[s];
         d_st_ff[s+1]  <= d_st_ff[s];
         d_rem_ff[s+1] <= d_rem_in[s];
         d_quo_ff[s+1] <= d_quo_in[s];
         d_dsr_ff[s+1] <= d_dsr_ff[s];
      end
   end

   // sign the quotient and pick the result
   assign out_res_in = d_div_ff[DIV_STEPS] ?
                       (d_neg_ff[DIV_STEPS] ? 32'(-d_quo_ff[DIV_STEPS])
                                            : d_quo_ff[DIV_STEPS]) :
                       d_res_ff[DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= d_vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff.result <= out_res_in;
      rsp_payload_ff.status <= d_st_ff[DIV_STEPS];
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTH
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_payload_ff.status != ST_OK) |-> rsp_payload_ff.result == 32'sd0)
      else $error("error status with non-zero result");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> rsp_payload_ff.status <= ST_DIV)
      else $error("status code out of range");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      d_vld_ff[DIV_STEPS] |=> rsp_strobe_ff)
      else $error("result dropped at the output stage");
   a_div_no_status: assert property (@(posedge clock) disable iff (reset)
      d_vld_ff[0] && d_div_ff[0] |-> d_st_ff[0] == ST_OK)
      else $error("divide issued with an error status");
`endif

endmodule

// ===== rtl/checked_int32_alu.sv =====
// channel   ports                                   handshake
// request   start, busy, req_payload                taken when start & !busy
// response  rsp_strobe, rsp_payload                 valid for one cycle, no stall
//
// One request per cycle while busy is low; each response is registered through
// the queue, the operand stage with multiplier, the divider input stage, 32
// divider stages and the output register before it reaches the outputs.
// The 32 stage restoring divider sets the latency; all operations share it.
// Reset is synchronous and clears the queue and every valid bit.
// busy rises only when the request queue is full, which the back end avoids
// by draining one entry every cycle.
module checked_int32_alu #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cia_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output cia_pkg::rsp_type rsp_payload
);
   import cia_pkg::*;

   qstat_type qstat;
   cmd_type   push_data, pop_data;
   logic      push, pop;

   cia_front u_front (
      .start       (start),
      .req_payload (req_payload),
      .qstat       (qstat),
      .push        (push),
      .push_data   (push_data),
      .busy        (busy)
   );

   cia_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   cia_back u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
